// ===== hw/rtl/byte_ring_fifo_with_search_defines.svh =====
// Assertion macros for the byte ring FIFO with search.
// Used by the top level; define NO_ASSERTIONS to compile them away.
`ifndef BYTE_RING_FIFO_WITH_SEARCH_DEFINES_SVH
`define BYTE_RING_FIFO_WITH_SEARCH_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BRF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BRF_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BRF_ASSERT(label, clk, rst_n, prop, msg)
`define BRF_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/brfifo_pkg.sv =====
// Shared types and constants for the byte ring FIFO with search.
// No dependencies.
`default_nettype none
package brfifo_pkg;
    typedef enum logic [2:0] {
        CMD_PUSH     = 3'd0,
        CMD_POP      = 3'd1,
        CMD_PUSH_BLK = 3'd2,
        CMD_POP_BLK  = 3'd3,
        CMD_CLEAR    = 3'd4,
        CMD_FIND     = 3'd5,
        CMD_COMPARE  = 3'd6,
        CMD_NONE     = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_FIND,
        ST_MOD,
        ST_CMP,
        ST_DONE
    } state_t;

    localparam int unsigned BLK_BYTES = 8;
endpackage
`default_nettype wire

// ===== hw/rtl/brfifo_ram.sv =====
// Byte store of the ring: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none
module brfifo_ram #(
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [7:0]               wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [7:0]               rdata
);
    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/byte_ring_fifo_with_search.sv =====
// Byte ring FIFO with block transfer, pattern find and compare.
// Uses brfifo_pkg, brfifo_ram and the assertion macro header.
//
// A ring queue of bytes held in one synchronous RAM (one write and one read
// port, registered read data). The ring length is the capacity register,
// clamped to [2, min(DEPTH,256)]; one slot stays free. Writing capacity
// empties the ring. Each request runs in a small sequencer and returns one
// result, held in an output register until taken, so the next request can be
// taken while a result waits. Push block and pop block move one byte per
// cycle. Compare first reduces index_in modulo the ring length by repeated
// compare-and-subtract steps, then checks one byte per cycle; find scans the
// stored bytes one per cycle through the single RAM read port. Compare stops
// early on the first mismatch; find stops at the first full match.
`default_nettype none
`include "byte_ring_fifo_with_search_defines.svh"
module byte_ring_fifo_with_search
    import brfifo_pkg::*;
#(
    parameter int unsigned DEPTH     = 256,
    parameter int unsigned MAX_BLOCK = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [8:0]  cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  cmd,
    input  wire logic [7:0]  byte_in,
    input  wire logic [63:0] block_in,
    input  wire logic [3:0]  block_len,
    input  wire logic [7:0]  index_in,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             ok,
    output logic [7:0]       byte_out,
    output logic [63:0]      block_out,
    output logic [7:0]       found_index,
    output logic [7:0]       stored_count,
    output logic [7:0]       free_count
);
    localparam int unsigned AW   = $clog2(DEPTH);
    localparam int unsigned LIM  = (DEPTH < 256) ? DEPTH : 256;

    // ring length and pointers, 9 bits (up to 256)
    logic [8:0] cap_reg;
    logic [8:0] n;
    logic [8:0] head_reg, head_next, tail_reg, tail_next;
    logic [8:0] cnt;

    always_comb
    begin
        if (cap_reg < 9'd2)
            n = 9'd2;
        else if (cap_reg > 9'(LIM))
            n = 9'(LIM);
        else
            n = cap_reg;
    end

    assign cnt = (tail_reg >= head_reg) ? (tail_reg - head_reg)
                                        : (tail_reg + n - head_reg);

    function automatic logic [8:0] inc(input logic [8:0] p, input logic [8:0] len);
        inc = (p + 9'd1 == len) ? 9'd0 : p + 9'd1;
    endfunction

    state_t      state_reg, state_next;
    cmd_t        cmd_reg;
    logic [63:0] blk_reg;
    logic [3:0]  len_reg;
    logic [3:0]  k_reg, k_next;      // bytes done / match length / shift step
    logic [8:0]  ptr_reg, ptr_next;  // read or write pointer
    logic [8:0]  scan_reg, scan_next; // byte position whose data returns

    // output register
    logic        ovalid_reg;
    logic        ok_reg, ok_next;
    logic [7:0]  bout_reg, bout_next;
    logic [63:0] bkout_reg, bkout_next;
    logic [7:0]  found_reg, found_next;
    logic        fin;  // request finishes; the sequencer moves to ST_DONE

    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]  wdata, rdata;

    brfifo_ram #(.DEPTH(DEPTH)) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    logic accept;
    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE) || cfg_we;

    function automatic logic [7:0] pbyte(input logic [63:0] b, input logic [3:0] k);
        pbyte = b[{k[2:0], 3'b000} +: 8];
    endfunction

    logic [8:0] held_after;
    logic [8:0] free_after;
    logic [8:0] mlen9;
    logic [9:0] fsum;
    logic       match_b;
    logic [3:0] m_new;
    logic [14:0] shf;   // n shifted for the index reduction
    logic [8:0]  rmod;  // index after this reduction step

    always_comb
    begin
        m_new   = 4'd0;
        match_b = (rdata == pbyte(blk_reg, k_reg));
        if (match_b)
            m_new = k_reg + 4'd1;
        else if (rdata == pbyte(blk_reg, 4'd0))
            m_new = 4'd1;
        mlen9 = {5'd0, len_reg};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_t'(cmd))
                        CMD_PUSH:
                            state_next = (cnt < n - 9'd1) ? ST_WRITE : ST_DONE;
                        CMD_POP:
                            state_next = (cnt != 9'd0) ? ST_READ : ST_DONE;
                        CMD_PUSH_BLK:
                            state_next = ({5'd0, block_len} <= 9'(MAX_BLOCK) &&
                                          {5'd0, block_len} <= n - 9'd1 - cnt &&
                                          block_len != 4'd0) ? ST_WRITE : ST_DONE;
                        CMD_POP_BLK:
                            state_next = (cnt != 9'd0 && block_len != 4'd0 &&
                                          {5'd0, block_len} <= 9'(MAX_BLOCK) &&
                                          {5'd0, block_len} <= cnt) ? ST_READ : ST_DONE;
                        CMD_FIND:
                            state_next = (block_len != 4'd0 &&
                                          {5'd0, block_len} <= 9'(MAX_BLOCK) &&
                                          cnt != 9'd0) ? ST_FIND : ST_DONE;
                        CMD_COMPARE:
                            state_next = (block_len != 4'd0 &&
                                          {5'd0, block_len} <= 9'(MAX_BLOCK))
                                         ? ST_MOD : ST_DONE;
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_WRITE:
            begin
                if (cmd_reg == CMD_PUSH || k_reg + 4'd1 == len_reg)
                    state_next = ST_DONE;
            end
            ST_MOD:
            begin
                if (k_reg == 4'd0)
                    state_next = ST_CMP;
            end
            ST_READ, ST_FIND, ST_CMP:
            begin
                if (fin)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!ovalid_reg || !out_stall)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        we           = 1'b0;
        waddr        = AW'(tail_reg);
        wdata        = (cmd_reg == CMD_PUSH) ? blk_reg[7:0] : pbyte(blk_reg, k_reg);
        raddr        = AW'(ptr_reg);
        head_next    = head_reg;
        tail_next    = tail_reg;
        k_next       = k_reg;
        ptr_next     = ptr_reg;
        scan_next    = scan_reg;
        ok_next      = ok_reg;
        bout_next    = bout_reg;
        bkout_next   = bkout_reg;
        found_next   = found_reg;
        fin          = 1'b0;
        held_after   = 9'd0;
        free_after   = 9'd0;
        fsum         = 10'd0;
        shf          = 15'd0;
        rmod         = ptr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                ok_next    = 1'b0;
                bout_next  = 8'd0;
                bkout_next = 64'd0;
                found_next = 8'd0;
                k_next     = 4'd0;
                ptr_next   = head_reg;
                raddr      = AW'(head_reg);
                if (accept)
                begin
                    unique case (cmd_t'(cmd))
                        CMD_CLEAR:
                        begin
                            head_next = 9'd0;
                            tail_next = 9'd0;
                            ok_next   = 1'b1;
                        end
                        CMD_PUSH_BLK:
                            ok_next = ({5'd0, block_len} <= 9'(MAX_BLOCK) &&
                                       {5'd0, block_len} <= n - 9'd1 - cnt);
                        CMD_POP_BLK:
                            ok_next = (cnt != 9'd0 && block_len == 4'd0);
                        CMD_COMPARE:
                            ok_next = (block_len == 4'd0);
                        CMD_FIND:
                            if (block_len != 4'd0 && {5'd0, block_len} <= 9'(MAX_BLOCK))
                                found_next = tail_reg[7:0];
                        CMD_PUSH, CMD_POP, CMD_NONE:
                            ok_next = 1'b0;
                        default:
                            ok_next = 1'b0;
                    endcase
                    if (cmd_t'(cmd) == CMD_COMPARE)
                    begin
                        // index_in is reduced modulo n before the first read
                        ptr_next = {1'b0, index_in};
                        k_next   = 4'd6;
                    end
                    else
                    begin
                        scan_next = head_reg;
                        ptr_next  = inc(head_reg, n);
                    end
                end
            end
            ST_WRITE:
            begin
                we        = 1'b1;
                tail_next = inc(tail_reg, n);
                k_next    = k_reg + 4'd1;
                if (state_next == ST_DONE)
                begin
                    ok_next = 1'b1;
                    fin     = 1'b1;
                end
            end
            ST_READ:
            begin
                // rdata is byte at head
                raddr     = AW'(ptr_reg);
                head_next = inc(head_reg, n);
                ptr_next  = inc(ptr_reg, n);
                if (cmd_reg == CMD_POP)
                begin
                    bout_next = rdata;
                    ok_next   = 1'b1;
                    fin       = 1'b1;
                end
                else
                begin
                    bkout_next = bkout_reg | ({56'd0, rdata} << {k_reg[2:0], 3'b000});
                    k_next     = k_reg + 4'd1;
                    if (k_reg + 4'd1 == len_reg)
                    begin
                        ok_next = 1'b1;
                        fin     = 1'b1;
                    end
                end
            end
            ST_FIND:
            begin
                // rdata is byte at scan_reg
                raddr     = AW'(ptr_reg);
                ptr_next  = inc(ptr_reg, n);
                scan_next = inc(scan_reg, n);
                k_next    = m_new;
                if (m_new == len_reg)
                begin
                    ok_next = 1'b1;
                    fsum    = {1'b0, scan_reg} + {1'b0, n} + 10'd1 - {1'b0, mlen9};
                    if (fsum >= {1'b0, n})
                        fsum = fsum - {1'b0, n};
                    if (fsum >= {1'b0, n})
                        fsum = fsum - {1'b0, n};
                    found_next = fsum[7:0];
                    fin        = 1'b1;
                end
                else if (inc(scan_reg, n) == tail_reg)
                begin
                    fsum = {1'b0, tail_reg} + {1'b0, n} - {6'd0, m_new};
                    if (fsum >= {1'b0, n})
                        fsum = fsum - {1'b0, n};
                    found_next = fsum[7:0];
                    fin        = 1'b1;
                end
            end
            ST_MOD:
            begin
                // restoring remainder: subtract n << k when it fits, k = 6..0
                shf = {6'd0, n} << k_reg[2:0];
                if ({6'd0, ptr_reg} >= shf)
                    rmod = ptr_reg - shf[8:0];
                if (k_reg == 4'd0)
                begin
                    raddr    = AW'(rmod);
                    ptr_next = inc(rmod, n);
                end
                else
                begin
                    ptr_next = rmod;
                    k_next   = k_reg - 4'd1;
                end
            end
            ST_CMP:
            begin
                raddr    = AW'(ptr_reg);
                k_next   = k_reg + 4'd1;
                ptr_next = inc(ptr_reg, n);
                if (!match_b)
                begin
                    ok_next = 1'b0;
                    fin     = 1'b1;
                end
                else if (k_reg + 4'd1 == len_reg)
                begin
                    ok_next = 1'b1;
                    fin     = 1'b1;
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
        held_after = (tail_next >= head_next) ? (tail_next - head_next)
                                              : (tail_next + n - head_next);
        free_after = n - 9'd1 - held_after;
    end

    logic load_out;
    assign load_out = (state_reg == ST_DONE) && (!ovalid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cap_reg     <= 9'd256;
            head_reg    <= 9'd0;
            tail_reg    <= 9'd0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            if (cfg_we)
            begin
                cap_reg  <= cfg_wdata;
                head_reg <= 9'd0;
                tail_reg <= 9'd0;
            end
            else
            begin
                head_reg <= head_next;
                tail_reg <= tail_next;
            end
            if (load_out)
                ovalid_reg <= 1'b1;
            else if (!out_stall)
                ovalid_reg <= 1'b0;
        end
    end

    // working and result payload registers
    logic [7:0] so_ok_cnt;
    logic [7:0] so_free;
    logic       w_ok;
    logic [7:0] w_bout, w_found;
    logic [63:0] w_bkout;
    logic        r_ok;
    logic [7:0]  r_bout, r_found, r_cnt, r_free;
    logic [63:0] r_bkout;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_t'(cmd);
            blk_reg <= (cmd_t'(cmd) == CMD_PUSH) ? {56'd0, byte_in} : block_in;
            len_reg <= block_len;
        end
        k_reg     <= k_next;
        ptr_reg   <= ptr_next;
        scan_reg  <= scan_next;
        w_ok      <= ok_next;
        w_bout    <= bout_next;
        w_bkout   <= bkout_next;
        w_found   <= found_next;
        so_ok_cnt <= held_after[7:0];
        so_free   <= free_after[7:0];
        if (load_out)
        begin
            r_ok    <= w_ok;
            r_bout  <= w_bout;
            r_bkout <= w_bkout;
            r_found <= w_found;
            r_cnt   <= so_ok_cnt;
            r_free  <= so_free;
        end
    end

    assign ok_reg    = w_ok;
    assign bout_reg  = w_bout;
    assign bkout_reg = w_bkout;
    assign found_reg = w_found;

    assign out_valid    = ovalid_reg;
    assign ok           = r_ok;
    assign byte_out     = r_bout;
    assign block_out    = r_bkout;
    assign found_index  = r_found;
    assign stored_count = r_cnt;
    assign free_count   = r_free;

    `BRF_ASSERT(a_head_in_ring, clk, rst_n, head_reg < n, "head beyond ring length")
    `BRF_ASSERT(a_tail_in_ring, clk, rst_n, tail_reg < n, "tail beyond ring length")
    `BRF_ASSERT(a_one_at_a_time, clk, rst_n, accept |=> state_reg != ST_IDLE,
                "request taken but sequencer stayed idle")
    `BRF_ASSERT(a_no_write_idle, clk, rst_n, state_reg == ST_IDLE |-> !we,
                "ring written while idle")
endmodule
`default_nettype wire

// ===== bench/byte_ring_fifo_with_search_tb.sv =====
// Self-checking bench for the byte ring FIFO with find and compare.
// Depends on brfifo_pkg and byte_ring_fifo_with_search; a local predictor
// tracks the ring and checks every result against a queue of expected results.
`timescale 1ns / 100ps
`default_nettype none
module byte_ring_fifo_with_search_tb
    import brfifo_pkg::*;
();

    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned DRAIN_CYCLES = 300;

    // One request as driven on the input ports
    typedef struct {
        cmd_t        op;
        logic [7:0]  byte_val;
        logic [63:0] blk;
        logic [3:0]  len;
        logic [7:0]  idx;
    } req_t;

    // One result as seen on the output ports
    typedef struct packed {
        logic        ok;
        logic [7:0]  byte_val;
        logic [63:0] blk;
        logic [7:0]  found;
        logic [7:0]  stored;
        logic [7:0]  free_sp;
    } rsp_t;

    // Directed row: request, plus an optional typed-in expectation
    typedef struct {
        req_t req;
        bit   has_exp;
        rsp_t exp;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [8:0]  cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  cmd;
    logic [7:0]  byte_in;
    logic [63:0] block_in;
    logic [3:0]  block_len;
    logic [7:0]  index_in;
    logic        out_valid;
    logic        out_stall;
    logic        ok;
    logic [7:0]  byte_out;
    logic [63:0] block_out;
    logic [7:0]  found_index;
    logic [7:0]  stored_count;
    logic [7:0]  free_count;

    byte_ring_fifo_with_search u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .byte_in      (byte_in),
        .block_in     (block_in),
        .block_len    (block_len),
        .index_in     (index_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .ok           (ok),
        .byte_out     (byte_out),
        .block_out    (block_out),
        .found_index  (found_index),
        .stored_count (stored_count),
        .free_count   (free_count)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Predictor state: ring contents, pointers, clamped ring length.
    // written_mask tracks which slots hold pushed data, so compares
    // never touch slots that were never written.
    logic [7:0] ring_mem [256];
    bit         written_mask [256];
    int unsigned head_p, tail_p, ring_n;

    rsp_t       expected_q [$];
    int unsigned fail_count;
    int unsigned idle_cycles;
    bit          stim_done;

    function automatic int unsigned clamp_len(logic [8:0] cap);
        if (cap < 2)
            return 2;
        if (cap > 256)
            return 256;
        return cap;
    endfunction

    function automatic int unsigned fill_level();
        return (tail_p >= head_p) ? tail_p - head_p : tail_p + ring_n - head_p;
    endfunction

    function automatic logic [7:0] pat_at(logic [63:0] blk, int unsigned k);
        return blk[(k % 8) * 8 +: 8];
    endfunction

    // Advance the ring model by one request and return the expected result
    function automatic rsp_t ring_predict(req_t r);
        rsp_t        e;
        int unsigned held_n, i, m;
        bit          hit;
        e = '{default: '0};
        held_n = fill_level();
        case (r.op)
            CMD_PUSH:
                if (held_n < ring_n - 1)
                begin
                    ring_mem[tail_p] = r.byte_val;
                    written_mask[tail_p] = 1'b1;
                    tail_p = (tail_p + 1) % ring_n;
                    e.ok = 1'b1;
                end
            CMD_POP:
                if (held_n != 0)
                begin
                    e.byte_val = ring_mem[head_p];
                    head_p = (head_p + 1) % ring_n;
                    e.ok = 1'b1;
                end
            CMD_PUSH_BLK:
                if (r.len <= 8 && r.len <= ring_n - 1 - held_n)
                begin
                    for (int k = 0; k < r.len; k++)
                    begin
                        ring_mem[tail_p] = pat_at(r.blk, k);
                        written_mask[tail_p] = 1'b1;
                        tail_p = (tail_p + 1) % ring_n;
                    end
                    e.ok = 1'b1;
                end
            CMD_POP_BLK:
                if (held_n != 0 && r.len <= 8 && r.len <= held_n)
                begin
                    for (int k = 0; k < r.len; k++)
                    begin
                        e.blk[k * 8 +: 8] = ring_mem[head_p];
                        head_p = (head_p + 1) % ring_n;
                    end
                    e.ok = 1'b1;
                end
            CMD_CLEAR:
            begin
                head_p = 0;
                tail_p = 0;
                e.ok = 1'b1;
            end
            CMD_FIND:
                if (r.len != 0 && r.len <= 8)
                begin
                    // restart retests the current byte as a first pattern byte
                    i = head_p;
                    m = 0;
                    hit = 1'b0;
                    while (i != tail_p)
                    begin
                        if (ring_mem[i] == pat_at(r.blk, m))
                            m++;
                        else
                            m = (ring_mem[i] == pat_at(r.blk, 0)) ? 1 : 0;
                        if (m == r.len)
                        begin
                            hit = 1'b1;
                            break;
                        end
                        i = (i + 1) % ring_n;
                    end
                    if (hit)
                    begin
                        e.found = 8'((i + ring_n + 1 - r.len) % ring_n);
                        e.ok = 1'b1;
                    end
                    else
                        e.found = 8'((tail_p + ring_n - m) % ring_n);
                end
            CMD_COMPARE:
                if (r.len <= 8)
                begin
                    e.ok = 1'b1;
                    for (int k = 0; k < r.len; k++)
                        if (ring_mem[(r.idx + k) % ring_n] != pat_at(r.blk, k))
                        begin
                            e.ok = 1'b0;
                            break;
                        end
                end
            default: ;
        endcase
        held_n = fill_level();
        e.stored = 8'(held_n);
        e.free_sp = 8'(ring_n - 1 - held_n);
        return e;
    endfunction

    // A compare is legal only if every slot it can touch was written
    function automatic bit compare_safe(req_t r);
        if (r.len > 8)
            return 1'b1;
        for (int k = 0; k < r.len; k++)
            if (!written_mask[(r.idx + k) % ring_n])
                return 1'b0;
        return 1'b1;
    endfunction

    // Send one request: random gap, then hold until accepted
    task automatic send_req(req_t r, bit has_exp, rsp_t typed);
        rsp_t e;
        int   gap;
        gap = (($urandom % 4) == 0) ? 0 : $urandom_range(0, 16);
        repeat (gap) @(negedge clk);
        cmd = r.op;
        byte_in = r.byte_val;
        block_in = r.blk;
        block_len = r.len;
        index_in = r.idx;
        in_valid = 1'b1;
        e = ring_predict(r);
        if (has_exp && e != typed)
        begin
            $display("%0t: table row disagrees with predictor", $time);
            fail_count++;
        end
        expected_q.push_back(has_exp ? typed : e);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Capacity write at an idle point: drain, settle, then write
    task automatic set_capacity(logic [8:0] cap);
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_wdata = cap;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        ring_n = clamp_len(cap);
        head_p = 0;
        tail_p = 0;
    endtask

    function automatic req_t mk(cmd_t op, logic [7:0] b, logic [63:0] blk,
                                logic [3:0] len, logic [7:0] idx);
        req_t r;
        r.op = op;
        r.byte_val = b;
        r.blk = blk;
        r.len = len;
        r.idx = idx;
        return r;
    endfunction

    function automatic rsp_t mkr(logic k, logic [7:0] st, logic [7:0] fr);
        rsp_t e;
        e = '{default: '0};
        e.ok = k;
        e.stored = st;
        e.free_sp = fr;
        return e;
    endfunction

    // Random request, weighted toward well-formed pushes, pops and
    // searches for patterns taken from the stored bytes
    function automatic req_t rand_req();
        req_t        r;
        int unsigned sel, held_n, start;
        sel = $urandom_range(0, 99);
        r = mk(CMD_NONE, 8'($urandom), {$urandom, $urandom},
               4'($urandom_range(0, 8)), 8'($urandom));
        if (sel < 1)
            r.len = 4'($urandom_range(9, 15));
        if (sel < 22)
            r.op = CMD_PUSH;
        else if (sel < 40)
            r.op = CMD_POP;
        else if (sel < 58)
            r.op = CMD_PUSH_BLK;
        else if (sel < 74)
            r.op = CMD_POP_BLK;
        else if (sel < 76)
            r.op = CMD_CLEAR;
        else if (sel < 88)
            r.op = CMD_FIND;
        else if (sel < 98)
            r.op = CMD_COMPARE;
        held_n = fill_level();
        // small alphabet so finds hit partial matches often
        if ($urandom_range(0, 1) && r.op inside {CMD_PUSH, CMD_PUSH_BLK, CMD_FIND})
        begin
            r.byte_val = 8'($urandom_range(0, 2));
            for (int k = 0; k < 8; k++)
                r.blk[k * 8 +: 8] = 8'($urandom_range(0, 2));
        end
        // lift a pattern from the stored data so finds and compares match
        if (held_n != 0 && r.len <= 8 && $urandom_range(0, 1)
            && r.op inside {CMD_FIND, CMD_COMPARE})
        begin
            start = (head_p + $urandom_range(0, held_n - 1)) % ring_n;
            r.idx = 8'(start);
            for (int k = 0; k < r.len; k++)
                r.blk[k * 8 +: 8] = ring_mem[(start + k) % ring_n];
        end
        if (r.op == CMD_COMPARE && !compare_safe(r))
            r.len = 0;
        return r;
    endfunction

    // Result checker with random output stalls
    always @(posedge clk)
    begin
        rsp_t got, e;
        if (rst_n && out_valid && !out_stall)
        begin
            got.ok = ok;
            got.byte_val = byte_out;
            got.blk = block_out;
            got.found = found_index;
            got.stored = stored_count;
            got.free_sp = free_count;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result ok=%0b cnt=%0d", $time, ok, stored_count);
                fail_count++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (got.ok !== e.ok)
                    $display("%0t: ok exp %0b got %0b", $time, e.ok, got.ok);
                if (got.byte_val !== e.byte_val)
                    $display("%0t: byte_out exp %h got %h", $time, e.byte_val, got.byte_val);
                if (got.blk !== e.blk)
                    $display("%0t: block_out exp %h got %h", $time, e.blk, got.blk);
                if (got.found !== e.found)
                    $display("%0t: found_index exp %0d got %0d", $time, e.found, got.found);
                if (got.stored !== e.stored)
                    $display("%0t: stored_count exp %0d got %0d", $time, e.stored, got.stored);
                if (got.free_sp !== e.free_sp)
                    $display("%0t: free_count exp %0d got %0d", $time, e.free_sp, got.free_sp);
                if (got !== e)
                    fail_count++;
            end
        end
    end

    // Output stall: a random wait per result, with calm stretches
    initial
    begin
        int w;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (out_valid)
            begin
                w = (($urandom % 4) == 0) ? 0 : $urandom_range(0, 16);
                if (w != 0)
                begin
                    out_stall = 1'b1;
                    repeat (w) @(negedge clk);
                    out_stall = 1'b0;
                end
                @(posedge clk);
            end
        end
    end

    // Watchdog: cycles with no request or result accepted
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we
            || (stim_done && expected_q.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    row_t table_rows [$];

    initial
    begin
        logic [8:0] caps [5];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        cmd = CMD_NONE;
        byte_in = '0;
        block_in = '0;
        block_len = '0;
        index_in = '0;
        fail_count = 0;
        idle_cycles = 0;
        stim_done = 1'b0;
        head_p = 0;
        tail_p = 0;
        ring_n = 256;
        foreach (written_mask[i])
            written_mask[i] = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed table: empty-ring errors, extremes, every command
        table_rows = '{
            '{mk(CMD_POP, 0, 0, 0, 0), 1, mkr(0, 0, 255)},
            '{mk(CMD_POP_BLK, 0, 0, 0, 0), 1, mkr(0, 0, 255)},
            '{mk(CMD_FIND, 0, 0, 0, 0), 1, mkr(0, 0, 255)},
            '{mk(CMD_COMPARE, 0, 0, 0, 0), 1, mkr(1, 0, 255)},
            '{mk(CMD_NONE, 8'hff, '1, 15, 8'hff), 1, mkr(0, 0, 255)},
            '{mk(CMD_PUSH, 8'hff, 0, 0, 0), 1, mkr(1, 1, 254)},
            '{mk(CMD_PUSH, 8'h00, 0, 0, 0), 1, mkr(1, 2, 253)},
            '{mk(CMD_PUSH_BLK, 0, 64'h0807060504030201, 8, 0), 1, mkr(1, 10, 245)},
            '{mk(CMD_PUSH_BLK, 0, '1, 9, 0), 1, mkr(0, 10, 245)},
            '{mk(CMD_PUSH_BLK, 0, '1, 0, 0), 1, mkr(1, 10, 245)},
            '{mk(CMD_PUSH_BLK, 0, 64'hffffffffffffffff, 8, 0), 0, mkr(0, 0, 0)},
            '{mk(CMD_FIND, 0, 64'h0403, 2, 0), 0, mkr(0, 0, 0)},
            '{mk(CMD_FIND, 0, 64'h0909, 2, 0), 0, mkr(0, 0, 0)},
            '{mk(CMD_FIND, 0, 64'h09ffff, 3, 0), 0, mkr(0, 0, 0)},
            '{mk(CMD_FIND, 0, 0, 9, 0), 0, mkr(0, 0, 0)},
            '{mk(CMD_COMPARE, 0, 64'h0201, 2, 2), 0, mkr(0, 0, 0)},
            '{mk(CMD_COMPARE, 0, 64'h0200, 2, 2), 0, mkr(0, 0, 0)},
            '{mk(CMD_COMPARE, 0, 0, 12, 0), 0, mkr(0, 0, 0)},
            '{mk(CMD_POP, 0, 0, 0, 0), 0, mkr(0, 0, 0)},
            '{mk(CMD_POP_BLK, 0, 0, 8, 0), 0, mkr(0, 0, 0)},
            '{mk(CMD_POP_BLK, 0, 0, 0, 0), 0, mkr(0, 0, 0)},
            '{mk(CMD_POP_BLK, 0, 0, 10, 0), 0, mkr(0, 0, 0)},
            '{mk(CMD_POP_BLK, 0, 0, 8, 0), 0, mkr(0, 0, 0)},
            '{mk(CMD_CLEAR, 0, 0, 0, 0), 1, mkr(1, 0, 255)}
        };
        foreach (table_rows[i])
            send_req(table_rows[i].req, table_rows[i].has_exp, table_rows[i].exp);

        // Random phases across ring sizes, starting at the smallest ring
        caps = '{9'd0, 9'd3, 9'd17, 9'd511, 9'd256};
        foreach (caps[p])
        begin
            set_capacity(caps[p]);
            for (int n = 0; n < 400; n++)
                send_req(rand_req(), 1'b0, '{default: '0});
        end

        stim_done = 1'b1;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ===== byte_ring_fifo_with_search.f =====
+incdir+hw/rtl
hw/rtl/brfifo_pkg.sv
hw/rtl/brfifo_ram.sv
hw/rtl/byte_ring_fifo_with_search.sv
bench/byte_ring_fifo_with_search_tb.sv
